### design/assert_macros.svh
// Assertion macros shared by the design files.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### design/lqp_pkg.sv
package lqp_pkg;

  // Field widths.
  localparam int ColorW   = 8;
  localparam int RgbW     = 24;
  localparam int PercentW = 7;
  localparam int CodeW    = 2;
  localparam int WordW    = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  // Number of 2-bit codes that fit in one packed word.
  localparam int CodesPerWord = WordW / CodeW;

  // Percentages above this value are clamped.
  localparam logic [PercentW-1:0] PercentFull = 7'd100;

  // Register reset values.
  localparam logic [PercentW-1:0] RangeReset  = 7'd50;
  localparam logic [RgbW-1:0]     TranspReset = 24'hFF00FF;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegRange  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTransp = 2'd1;

  // Pixel codes.
  typedef enum logic [CodeW-1:0] {
    CODE_DARK   = 2'd0,
    CODE_LIGHT  = 2'd1,
    CODE_TRANSP = 2'd2,
    CODE_MIDDLE = 2'd3
  } code_t;

  // Request types.
  localparam logic ReqMeasure = 1'b0;
  localparam logic ReqConvert = 1'b1;

  // One input word: a pixel and its request.
  typedef struct packed {
    logic              req_type;
    logic              first_of_pass;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } pix_t;

  // One output word.
  typedef struct packed {
    logic [CodeW-1:0] pixel_code;
    logic             word_ready;
    logic [WordW-1:0] packed_word;
  } res_t;

  // Classifier results handed back to the top level.
  typedef struct packed {
    code_t             code;
    logic [ColorW-1:0] light;
    logic              transparent;
  } cls_t;

endpackage

### design/lqp_if.sv
// Pixel channel: carries one pixel word per handshake.
interface lqp_pix_if;
  logic          valid;
  logic          ready;
  lqp_pkg::pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel: carries one code word per handshake.
interface lqp_res_if;
  logic          valid;
  logic          ready;
  lqp_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/lqp_classify.sv
// Lightness, transparency and 2-bit code of one pixel against the current range.
module lqp_classify (
  input  lqp_pkg::pix_t                      pix,
  input  logic [lqp_pkg::ColorW-1:0]         low_light,
  input  logic [lqp_pkg::ColorW-1:0]         high_light,
  input  logic [lqp_pkg::PercentW-1:0]       range_percent,
  input  logic [lqp_pkg::RgbW-1:0]           transparent_rgb,
  output lqp_pkg::cls_t                      cls
);

  logic [7:0]         max_c;
  logic [7:0]         min_c;
  logic [8:0]         light_sum;
  logic [7:0]         light;
  logic               transparent;
  logic [6:0]         pct;
  logic [7:0]         span;
  logic [6:0]         dist_low;
  logic [7:0]         dist_high;
  logic [8:0]         mid_sum;
  logic [7:0]         mid;
  logic [14:0]        prod_high;
  logic [13:0]        prod_low;
  logic signed [9:0]  x_high;
  logic signed [9:0]  x_low;
  logic signed [17:0] lim_high;
  logic signed [17:0] lim_low;
  logic               is_light;
  logic               is_dark;

  // Lightness is (max + min + 1) / 2 of the three components.
  always_comb begin
    max_c = pix.red;
    min_c = pix.red;
    if (pix.green > max_c) max_c = pix.green;
    if (pix.blue > max_c) max_c = pix.blue;
    if (pix.green < min_c) min_c = pix.green;
    if (pix.blue < min_c) min_c = pix.blue;
  end

  assign light_sum   = 9'(max_c) + 9'(min_c) + 9'd1;
  assign light       = light_sum[8:1];
  assign transparent = ({pix.red, pix.green, pix.blue} == transparent_rgb);

  // Clamp the percentage and split the range around its midpoint.
  // The range always has high_light >= low_light.
  assign pct       = (range_percent > lqp_pkg::PercentFull) ? lqp_pkg::PercentFull
                                                            : range_percent;
  assign span      = high_light - low_light;
  assign dist_low  = span[7:1];
  assign dist_high = span - 8'(dist_low);
  assign mid_sum   = 9'(low_light) + 9'(high_light);
  assign mid       = mid_sum[8:1];

  // Breakpoint offsets before the division by 100.
  assign prod_high = 15'(dist_high) * 15'(pct);
  assign prod_low  = 14'(dist_low) * 14'(pct);

  // light >= mid + floor(p / 100) holds exactly when p < 100 * (light - mid + 1),
  // and light <= mid - floor(p / 100) when p < 100 * (mid - light + 1).
  // This avoids a divider in the path.
  assign x_high   = $signed({2'b00, light}) - $signed({2'b00, mid}) + 10'sd1;
  assign x_low    = $signed({2'b00, mid}) - $signed({2'b00, light}) + 10'sd1;
  assign lim_high = 18'(x_high) * 18'sd100;
  assign lim_low  = 18'(x_low) * 18'sd100;
  assign is_light = $signed({3'b000, prod_high}) < lim_high;
  assign is_dark  = $signed({4'b0000, prod_low}) < lim_low;

  // Code priority: transparent, light, dark, middle.
  always_comb begin
    cls.light       = light;
    cls.transparent = transparent;
    if (transparent) begin
      cls.code = lqp_pkg::CODE_TRANSP;
    end else if (is_light) begin
      cls.code = lqp_pkg::CODE_LIGHT;
    end else if (is_dark) begin
      cls.code = lqp_pkg::CODE_DARK;
    end else begin
      cls.code = lqp_pkg::CODE_MIDDLE;
    end
  end

endmodule

### design/lightness_quantize_pack_2bpp_top.sv
// Channel  | Dir | Word                                             | Handshake
// pixel    | in  | req_type, first_of_pass, red, green, blue        | valid/ready
// result   | out | pixel_code, word_ready, packed_word              | valid/ready
// cfg      | in  | cfg_index, cfg_data (0 range_percent, 1 transp)  | cfg_write
//
// One pixel is accepted per clock unless a convert word waits on a stalled result.
// Convert words leave through the result register; a measure word produces no output.
// The input register and the result register bound a single stage that classifies
// the pixel and updates range and packer state. rst is synchronous and clears both.
// A stalled result holds a convert word in the stage; measure words still move on.
`include "assert_macros.svh"

module lightness_quantize_pack_2bpp_top #(
  parameter int PIXELS_PER_WORD = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lqp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [lqp_pkg::CfgDataW-1:0]  cfg_data,
  lqp_pix_if.sink                       pixel,
  lqp_res_if.source                     result
);

  localparam int PosW = $clog2(PIXELS_PER_WORD);
  localparam logic [PosW-1:0] LastPos = PosW'(PIXELS_PER_WORD - 1);

  logic [lqp_pkg::PercentW-1:0] range_percent;
  logic [lqp_pkg::RgbW-1:0]     transparent_rgb;
  logic                         stage_valid;
  lqp_pkg::pix_t                stage;
  logic [lqp_pkg::ColorW-1:0]   low_light;
  logic [lqp_pkg::ColorW-1:0]   high_light;
  logic [lqp_pkg::WordW-1:0]    pack_accum;
  logic [PosW-1:0]              pack_position;
  logic                         out_valid;
  lqp_pkg::res_t                out_data;

  lqp_pkg::cls_t                cls;
  logic                         advance;
  logic                         is_convert;
  logic [lqp_pkg::WordW-1:0]    acc_base;
  logic [lqp_pkg::WordW-1:0]    acc_next;
  logic [PosW-1:0]              pos_base;
  logic                         word_done;
  logic                         word_fire;
  logic                         packer_empty;
  logic                         stray_word;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_percent   <= lqp_pkg::RangeReset;
      transparent_rgb <= lqp_pkg::TranspReset;
    end else if (cfg_write) begin
      case (cfg_index)
        lqp_pkg::RegRange:  range_percent   <= cfg_data[lqp_pkg::PercentW-1:0];
        lqp_pkg::RegTransp: transparent_rgb <= cfg_data[lqp_pkg::RgbW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: measure words always move on, convert words need result space.
  assign is_convert  = (stage.req_type == lqp_pkg::ReqConvert);
  assign advance     = stage_valid && (!is_convert || !out_valid || result.ready);
  assign pixel.ready = !stage_valid || advance;

  // Pixel input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (pixel.ready) begin
      stage_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      stage <= pixel.data;
    end
  end

  lqp_classify u_classify (
    .pix             (stage),
    .low_light       (low_light),
    .high_light      (high_light),
    .range_percent   (range_percent),
    .transparent_rgb (transparent_rgb),
    .cls             (cls)
  );

  // Insert the new code into its slot; slots past the word width are dropped.
  always_comb begin
    acc_base  = stage.first_of_pass ? '0 : pack_accum;
    pos_base  = stage.first_of_pass ? '0 : pack_position;
    word_done = (pos_base == LastPos);
    acc_next  = acc_base;
    for (int k = 0; k < lqp_pkg::CodesPerWord; k++) begin
      if ((k < PIXELS_PER_WORD) && (pos_base == PosW'(k))) begin
        acc_next[lqp_pkg::CodeW*k +: lqp_pkg::CodeW] = cls.code;
      end
    end
  end

  // Range and packer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_light     <= '0;
      high_light    <= '0;
      pack_accum    <= '0;
      pack_position <= '0;
    end else if (advance) begin
      if (is_convert) begin
        pack_accum    <= word_done ? '0 : acc_next;
        pack_position <= word_done ? '0 : pos_base + PosW'(1);
      end else if (stage.first_of_pass) begin
        low_light  <= cls.light;
        high_light <= cls.light;
      end else if (!cls.transparent) begin
        if (cls.light < low_light) low_light <= cls.light;
        if (cls.light > high_light) high_light <= cls.light;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_convert) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_convert) begin
      out_data.pixel_code  <= cls.code;
      out_data.word_ready  <= word_done;
      out_data.packed_word <= word_done ? acc_next : '0;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Conditions watched by the checks below.
  assign word_fire    = advance && is_convert && word_done;
  assign packer_empty = (pack_accum == '0) && (pack_position == '0);
  assign stray_word   = out_valid && !out_data.word_ready && (out_data.packed_word != '0);

  // The tracked range never inverts.
  `ASSERT_CLK(a_range_order, high_light >= low_light, "range inverted")
  // The packer position stays inside one word.
  `ASSERT_CLK(a_pos_bound, pack_position <= LastPos, "pack position past word end")
  // A completed word leaves the packer empty.
  `ASSERT_CLK(a_word_clears, word_fire |=> packer_empty, "packer not cleared after word")
  // Only a completing pixel carries a packed word.
  `ASSERT_NEVER(a_word_zero, stray_word, "packed word without completion")

endmodule

### tb/lightness_quantize_pack_2bpp_top_tb.sv
module lightness_quantize_pack_2bpp_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PixelsPerWord = 8;
  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 6;
  localparam logic [lqp_pkg::CfgIdxW-1:0] RegSpare = 2'd3;

  logic                         clk;
  logic                         rst;
  logic                         cfg_write;
  logic [lqp_pkg::CfgIdxW-1:0]  cfg_index;
  logic [lqp_pkg::CfgDataW-1:0] cfg_data;

  lqp_pix_if pixel ();
  lqp_res_if result ();

  lightness_quantize_pack_2bpp_top #(
    .PIXELS_PER_WORD(PixelsPerWord)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel(pixel),
    .result(result)
  );

  // Pixel words waiting to be offered, and code words the block owes us.
  lqp_pkg::pix_t pending_pixels[$];
  lqp_pkg::res_t expected_codes[$];

  // Our own copy of the registers and of the range and packer state.
  logic [lqp_pkg::PercentW-1:0] range_pct;
  logic [lqp_pkg::RgbW-1:0]     transp_color;
  int                           range_lo;
  int                           range_hi;
  logic [lqp_pkg::WordW-1:0]    pack_word;
  int                           pack_slot;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int mismatches;
  int cycle_count;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Lightness: mean of the largest and smallest component, rounded half up.
  function automatic int lightness(lqp_pkg::pix_t p);
    int mx;
    int mn;
    mx = int'(p.red);
    mn = int'(p.red);
    if (int'(p.green) > mx) mx = int'(p.green);
    if (int'(p.blue) > mx) mx = int'(p.blue);
    if (int'(p.green) < mn) mn = int'(p.green);
    if (int'(p.blue) < mn) mn = int'(p.blue);
    return (mx + mn + 1) >> 1;
  endfunction

  // Update the range or classify and pack one accepted pixel.
  function automatic void classify_and_pack(lqp_pkg::pix_t p);
    int             light;
    int             pct;
    int             mid;
    int             low_break;
    int             high_break;
    logic           is_transp;
    lqp_pkg::code_t code;
    lqp_pkg::res_t  word;
    light = lightness(p);
    is_transp = ({p.red, p.green, p.blue} == transp_color);
    if (p.req_type == lqp_pkg::ReqMeasure) begin
      if (p.first_of_pass) begin
        range_lo = light;
        range_hi = light;
      end else if (!is_transp) begin
        if (light < range_lo) range_lo = light;
        if (light > range_hi) range_hi = light;
      end
      return;
    end
    pct = (range_pct > lqp_pkg::PercentFull) ? int'(lqp_pkg::PercentFull) : int'(range_pct);
    mid = (range_lo + range_hi) / 2;
    low_break = mid - ((mid - range_lo) * pct) / 100;
    high_break = mid + ((range_hi - mid) * pct) / 100;
    if (is_transp) code = lqp_pkg::CODE_TRANSP;
    else if (light >= high_break) code = lqp_pkg::CODE_LIGHT;
    else if (light <= low_break) code = lqp_pkg::CODE_DARK;
    else code = lqp_pkg::CODE_MIDDLE;
    // A new pass throws away any partly packed word.
    if (p.first_of_pass) begin
      pack_word = '0;
      pack_slot = 0;
    end
    if (pack_slot < lqp_pkg::CodesPerWord)
      pack_word = pack_word | ({{(lqp_pkg::WordW - lqp_pkg::CodeW){1'b0}}, code}
                               << (lqp_pkg::CodeW * pack_slot));
    word.pixel_code = code;
    word.word_ready = 1'b0;
    word.packed_word = '0;
    if (pack_slot + 1 >= PixelsPerWord) begin
      word.word_ready = 1'b1;
      word.packed_word = pack_word;
      pack_word = '0;
      pack_slot = 0;
    end else begin
      pack_slot++;
    end
    expected_codes.push_back(word);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 20) $display("ERROR %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  // Pixel sender: holds a word until accepted, then maybe idles.
  always @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (!pixel.valid || pixel.ready) begin
      if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pixel.valid <= 1'b1;
        pixel.data <= pending_pixels.pop_front();
      end else begin
        pixel.valid <= 1'b0;
      end
    end
  end

  // Accepted pixels feed the predictor.
  always @(posedge clk) begin
    if (!rst && pixel.valid && pixel.ready) classify_and_pack(pixel.data);
  end

  // Result receiver: random stalls, plus a long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      result.ready <= 1'b0;
      hold_cycles--;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted code word with the oldest expectation.
  always @(posedge clk) begin
    lqp_pkg::res_t want;
    if (!rst && result.valid && result.ready) begin
      if (expected_codes.size() == 0) begin
        report_mismatch("unexpected word", int'(result.data), 0);
      end else begin
        want = expected_codes.pop_front();
        if (result.data.pixel_code !== want.pixel_code)
          report_mismatch("pixel_code", int'(result.data.pixel_code), int'(want.pixel_code));
        if (result.data.word_ready !== want.word_ready)
          report_mismatch("word_ready", int'(result.data.word_ready), int'(want.word_ready));
        if (result.data.packed_word !== want.packed_word)
          report_mismatch("packed_word", int'(result.data.packed_word),
                          int'(want.packed_word));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("lightness_quantize_pack_2bpp_top: mismatch");
      $finish;
    end
  end

  task automatic queue_pixel(logic req, logic first, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b);
    lqp_pkg::pix_t p;
    p.req_type = req;
    p.first_of_pass = first;
    p.red = r;
    p.green = g;
    p.blue = b;
    pending_pixels.push_back(p);
  endtask

  // A pixel that is sometimes the transparent color, sometimes all extremes.
  task automatic queue_random_pixel(logic req, logic first);
    int pick;
    pick = int'($urandom_range(99));
    if (pick < 10) begin
      queue_pixel(req, first, transp_color[23:16], transp_color[15:8], transp_color[7:0]);
    end else if (pick < 20) begin
      queue_pixel(req, first, $urandom_range(1) ? 8'hFF : 8'h00,
                  $urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00);
    end else begin
      queue_pixel(req, first, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    end
  endtask

  // Mostly a measure pass followed by a convert pass, with some loose words.
  task automatic queue_random_passes(int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 80) begin
        len = int'($urandom_range(12, 1));
        for (int i = 0; i < len; i++) queue_random_pixel(lqp_pkg::ReqMeasure, i == 0);
        n += len;
        len = PixelsPerWord * int'($urandom_range(3, 1));
        if ($urandom_range(3) == 0) len += int'($urandom_range(PixelsPerWord - 1));
        for (int i = 0; i < len; i++) queue_random_pixel(lqp_pkg::ReqConvert, i == 0);
        n += len;
      end else begin
        len = int'($urandom_range(4, 1));
        for (int i = 0; i < len; i++)
          queue_random_pixel(1'($urandom_range(1)), 1'($urandom_range(1)));
        n += len;
      end
    end
  endtask

  // Wait until everything offered has been accepted and answered.
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || pixel.valid || expected_codes.size() != 0)
      @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [lqp_pkg::CfgIdxW-1:0] idx,
                           logic [lqp_pkg::CfgDataW-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == lqp_pkg::RegRange) range_pct = value[lqp_pkg::PercentW-1:0];
    else if (idx == lqp_pkg::RegTransp) transp_color = value;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Stimulus and phase control.
  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixel.valid = 1'b0;
    pixel.data = '0;
    result.ready = 1'b0;
    range_pct = lqp_pkg::RangeReset;
    transp_color = lqp_pkg::TranspReset;
    range_lo = 0;
    range_hi = 0;
    pack_word = '0;
    pack_slot = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    mismatches = 0;
    cycle_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed words on the reset register values, no idling.
    // A convert before any measure sees an empty range.
    queue_pixel(lqp_pkg::ReqConvert, 1'b1, 8'd0, 8'd0, 8'd0);
    // The first measure pixel sets the range even when transparent.
    queue_pixel(lqp_pkg::ReqMeasure, 1'b1, 8'hFF, 8'h00, 8'hFF);
    queue_pixel(lqp_pkg::ReqMeasure, 1'b0, 8'd0, 8'd0, 8'd0);
    queue_pixel(lqp_pkg::ReqMeasure, 1'b0, 8'd255, 8'd255, 8'd255);
    // Later transparent pixels leave the range alone.
    queue_pixel(lqp_pkg::ReqMeasure, 1'b0, 8'hFF, 8'h00, 8'hFF);
    queue_pixel(lqp_pkg::ReqMeasure, 1'b0, 8'd10, 8'd200, 8'd30);
    // One full word covering every code.
    queue_pixel(lqp_pkg::ReqConvert, 1'b1, 8'd0, 8'd0, 8'd0);
    queue_pixel(lqp_pkg::ReqConvert, 1'b0, 8'd255, 8'd255, 8'd255);
    queue_pixel(lqp_pkg::ReqConvert, 1'b0, 8'hFF, 8'h00, 8'hFF);
    queue_pixel(lqp_pkg::ReqConvert, 1'b0, 8'd128, 8'd128, 8'd128);
    queue_pixel(lqp_pkg::ReqConvert, 1'b0, 8'd64, 8'd64, 8'd64);
    queue_pixel(lqp_pkg::ReqConvert, 1'b0, 8'd192, 8'd192, 8'd192);
    queue_pixel(lqp_pkg::ReqConvert, 1'b0, 8'd255, 8'd0, 8'd0);
    queue_pixel(lqp_pkg::ReqConvert, 1'b0, 8'd0, 8'd0, 8'd255);
    // A restart in the middle of a word drops the partial word.
    queue_pixel(lqp_pkg::ReqConvert, 1'b0, 8'd255, 8'd255, 8'd255);
    queue_pixel(lqp_pkg::ReqConvert, 1'b0, 8'd0, 8'd0, 8'd0);
    queue_pixel(lqp_pkg::ReqConvert, 1'b1, 8'd255, 8'd254, 8'd1);
    for (int i = 0; i < PixelsPerWord - 1; i++)
      queue_pixel(lqp_pkg::ReqConvert, 1'b0, 8'(i * 36), 8'(255 - i * 36), 8'd77);
    // A collapsed range where both breakpoints meet: one pixel on them, one just below.
    queue_pixel(lqp_pkg::ReqMeasure, 1'b1, 8'd100, 8'd100, 8'd100);
    queue_pixel(lqp_pkg::ReqConvert, 1'b1, 8'd100, 8'd100, 8'd100);
    queue_pixel(lqp_pkg::ReqConvert, 1'b0, 8'd99, 8'd99, 8'd99);
    wait_idle();

    // Zero range, black transparent, a write to an unused index; sender idles.
    write_reg(lqp_pkg::RegRange, {17'h1ABCD, 7'd0});
    write_reg(lqp_pkg::RegTransp, 24'h000000);
    write_reg(RegSpare, 24'h7F7F7F);
    end_writes();
    send_idle_pct = 72;
    recv_stall_pct = 0;
    queue_random_passes(200);
    wait_idle();

    // Full range, white transparent; receiver stalls and holds off long.
    write_reg(lqp_pkg::RegRange, 24'd100);
    write_reg(lqp_pkg::RegTransp, 24'hFFFFFF);
    end_writes();
    send_idle_pct = 0;
    recv_stall_pct = 72;
    hold_cycles = 300;
    queue_random_passes(100);
    // The sender pauses here until the block has answered everything.
    wait_idle();
    queue_random_passes(100);
    wait_idle();

    // Range above full scale is clamped; both sides idle.
    write_reg(lqp_pkg::RegRange, 24'd127);
    write_reg(lqp_pkg::RegTransp, 24'($urandom_range(24'hFFFFFF)));
    end_writes();
    send_idle_pct = 21;
    recv_stall_pct = 21;
    queue_random_passes(200);
    wait_idle();

    // Random range, default transparent color again; no idling, one long hold.
    write_reg(lqp_pkg::RegTransp, lqp_pkg::TranspReset);
    write_reg(lqp_pkg::RegRange, 24'($urandom_range(99, 1)));
    end_writes();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 200;
    queue_random_passes(300);
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("lightness_quantize_pack_2bpp_top: match");
    end else begin
      $display("lightness_quantize_pack_2bpp_top: mismatch");
    end
    $finish;
  end

endmodule
